// File: rtl/unique_key_array_set_core_defines.svh
// assertion macros for the key set core
`ifndef UNIQUE_KEY_ARRAY_SET_CORE_DEFINES_SVH
`define UNIQUE_KEY_ARRAY_SET_CORE_DEFINES_SVH

`ifndef SYNTH

// property checked on every rising clock edge outside reset
`define UKAS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ukas assertion failed");

// condition that must never hold
`define UKAS_NEVER(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("ukas forbidden condition");

`else

`define UKAS_ASSERT(name, prop)

`define UKAS_NEVER(name, cond)

`endif

`endif

// File: rtl/ukas_pkg.sv
// shared constants and types of the key set core
package ukas_pkg;

   localparam int DEPTH   = 16;
   localparam int AW      = $clog2(DEPTH);
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int KEY_W   = 32;
   localparam int OP_W    = 2;
   localparam int IDX_W   = 4;
   localparam int POS_W   = 4;
   localparam int CNT_W   = 5;
   localparam int CAP_W   = 5;
   localparam int ST_W    = 3;
   localparam int CAP_RST = 16;

   localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd1;
   localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
   localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;

   typedef struct packed {
      logic             rd_en;
      logic [AW-1:0]    rd_addr;
      logic             wr_en;
      logic [AW-1:0]    wr_addr;
      logic [KEY_W-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic [POS_W-1:0]        position;
      logic signed [KEY_W-1:0] key_out;
      logic [CNT_W-1:0]        count;
      logic signed [KEY_W-1:0] first_key;
      logic signed [KEY_W-1:0] last_key;
   } result_type;

endpackage

// File: rtl/ukas_if.sv
// channel interfaces of the key set core
interface ukas_req_if import ukas_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic signed [KEY_W-1:0] key;
   logic [IDX_W-1:0]        index;
   modport source (output valid, op, key, index, input ready);
   modport sink (input valid, op, key, index, output ready);
endinterface

interface ukas_rsp_if import ukas_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic [POS_W-1:0]        position;
   logic signed [KEY_W-1:0] key_out;
   logic [CNT_W-1:0]        count;
   logic signed [KEY_W-1:0] first_key;
   logic signed [KEY_W-1:0] last_key;
   modport source (output valid, status, position, key_out, count, first_key, last_key,
                   input ready);
   modport sink (input valid, status, position, key_out, count, first_key, last_key,
                 output ready);
endinterface

interface ukas_csr_if import ukas_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: rtl/ukas_ram.sv
// key storage, one write and one registered read port
module ukas_ram import ukas_pkg::*; (
   input  logic              clock,
   input  mem_req_type       mem,
   output logic [KEY_W-1:0]  rd_data
);

   logic [KEY_W-1:0] store_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem.wr_en) begin
         store_ff[mem.wr_addr] <= mem.wr_data;
      end
      if (mem.rd_en) begin
         rd_data_ff <= store_ff[mem.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ukas_ctrl.sv
// sequencer with the shared key comparator
`include "unique_key_array_set_core_defines.svh"
module ukas_ctrl import ukas_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ukas_req_if.sink         req_chan,
   input  logic [CW-1:0]    limit,
   output mem_req_type      mem,
   input  logic [KEY_W-1:0] rd_data,
   output logic             done_valid,
   input  logic             done_ready,
   output result_type       done
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_CMP    = 4'd2;
   localparam logic [3:0] S_ACT    = 4'd3;
   localparam logic [3:0] S_SHRD   = 4'd4;
   localparam logic [3:0] S_SHWR   = 4'd5;
   localparam logic [3:0] S_RDIDX  = 4'd6;
   localparam logic [3:0] S_RDCAP  = 4'd7;
   localparam logic [3:0] S_FETCH0 = 4'd8;
   localparam logic [3:0] S_FETCH1 = 4'd9;
   localparam logic [3:0] S_FETCH2 = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [CW-1:0]    used_ff, used_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic             found_ff, found_in;
   logic [ST_W-1:0]  status_ff, status_in;
   logic [KEY_W-1:0] kout_ff, kout_in;
   logic [KEY_W-1:0] first_ff, first_in;
   logic [KEY_W-1:0] last_ff, last_in;
   logic             key_hit;

   // shared comparator
   assign key_hit = (rd_data == key_ff);

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      status_in = status_ff;
      kout_in   = kout_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      mem       = '0;
      done_valid = 1'b0;
      req_chan.ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.op;
               key_in    = req_chan.key;
               idx_in    = req_chan.index;
               ptr_in    = '0;
               pos_in    = '0;
               found_in  = 1'b0;
               status_in = ST_OK;
               kout_in   = '0;
               if (req_chan.op == OP_READ) begin
                  if (32'(req_chan.index) < 32'(used_ff)) begin
                     state_in = S_RDIDX;
                  end else begin
                     status_in = ST_RANGE;
                     state_in  = S_FETCH0;
                  end
               end else if (used_ff == '0) begin
                  state_in = S_ACT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = ptr_ff;
            state_in    = S_CMP;
         end
         S_CMP: begin
            if (key_hit) begin
               found_in = 1'b1;
               pos_in   = ptr_ff;
               state_in = S_ACT;
            end else if (32'(ptr_ff) + 1 < 32'(used_ff)) begin
               ptr_in   = ptr_ff + AW'(1);
               state_in = S_SCAN;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            state_in = S_FETCH0;
            case (op_ff)
               OP_SEARCH: begin
                  if (!found_ff) begin
                     status_in = ST_NOTFOUND;
                  end
               end
               OP_INSERT: begin
                  if (found_ff) begin
                     status_in = ST_DUP;
                  end else if (used_ff >= limit) begin
                     status_in = ST_FULL;
                  end else begin
                     mem.wr_en   = 1'b1;
                     mem.wr_addr = AW'(used_ff);
                     mem.wr_data = key_ff;
                     pos_in      = AW'(used_ff);
                     used_in     = used_ff + CW'(1);
                  end
               end
               OP_REMOVE: begin
                  if (!found_ff) begin
                     status_in = ST_NOTFOUND;
                  end else begin
                     ptr_in = pos_ff;
                     if (32'(pos_ff) + 1 < 32'(used_ff)) begin
                        state_in = S_SHRD;
                     end else begin
                        used_in = used_ff - CW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_SHRD: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = ptr_ff + AW'(1);
            state_in    = S_SHWR;
         end
         S_SHWR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = ptr_ff;
            mem.wr_data = rd_data;
            ptr_in      = ptr_ff + AW'(1);
            if (32'(ptr_ff) + 2 < 32'(used_ff)) begin
               state_in = S_SHRD;
            end else begin
               used_in  = used_ff - CW'(1);
               state_in = S_FETCH0;
            end
         end
         S_RDIDX: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = AW'(idx_ff);
            state_in    = S_RDCAP;
         end
         S_RDCAP: begin
            kout_in  = rd_data;
            state_in = S_FETCH0;
         end
         S_FETCH0: begin
            if (used_ff == '0) begin
               first_in = '0;
               last_in  = '0;
               state_in = S_DONE;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = '0;
               state_in    = S_FETCH1;
            end
         end
         S_FETCH1: begin
            first_in    = rd_data;
            mem.rd_en   = 1'b1;
            mem.rd_addr = AW'(used_ff - CW'(1));
            state_in    = S_FETCH2;
         end
         S_FETCH2: begin
            last_in  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      done.status    = status_ff;
      done.position  = (op_ff == OP_READ) ? POS_W'(idx_ff) : POS_W'(pos_ff);
      done.key_out   = kout_ff;
      done.count     = CNT_W'(used_ff);
      done.first_key = first_ff;
      done.last_key  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      kout_ff   <= kout_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
   end

   `UKAS_ASSERT(a_used_bound, 32'(used_ff) <= DEPTH)
   `UKAS_ASSERT(a_accept_leaves_idle, (req_chan.valid && req_chan.ready) |=> (state_ff != S_IDLE))
   `UKAS_ASSERT(a_write_states, mem.wr_en |-> (state_ff == S_ACT || state_ff == S_SHWR))
   `UKAS_ASSERT(a_used_step, (used_ff != $past(used_ff)) |-> ($past(state_ff) == S_ACT || $past(state_ff) == S_SHWR))
   `UKAS_NEVER(a_shift_past_end, (state_ff == S_SHRD) && (32'(ptr_ff) + 1 >= 32'(used_ff)))

endmodule

// File: rtl/unique_key_array_set_core.sv
// search, insert and remove scan the keys in order, a read and a compare per key, then fetch the first and last keys
// a remove then shifts each later key down one place, a read and a write per key; a read at an index reads that key
// an empty set skips the key reads; an index out of range skips the read at the index; both finish sooner
// the sequencer works on one word at a time; the single read port of the key store sets the pace
// the output register lets the next word be accepted while a result waits
// synchronous active-high reset empties the set and sets capacity to 16; keys are not cleared
module unique_key_array_set_core import ukas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ukas_req_if.sink   req_chan,
   ukas_rsp_if.source rsp_chan,
   ukas_csr_if.sink   csr_chan
);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CW-1:0]    limit;
   mem_req_type      mem;
   logic [KEY_W-1:0] rd_data;
   logic             done_valid;
   logic             done_ready;
   result_type       done;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;

   assign csr_chan.ready = 1'b1;
   assign cap_in = (csr_chan.valid) ? csr_chan.data : cap_ff;
   assign limit  = (32'(cap_ff) < DEPTH) ? CW'(cap_ff) : CW'(DEPTH);

   ukas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .limit      (limit),
      .mem        (mem),
      .rd_data    (rd_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done       (done)
   );

   ukas_ram u_ram (
      .clock   (clock),
      .mem     (mem),
      .rd_data (rd_data)
   );

   assign done_ready = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (done_valid && done_ready) begin
         out_valid_in = 1'b1;
         out_in       = done;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_W'(CAP_RST);
         out_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.status    = out_ff.status;
   assign rsp_chan.position  = out_ff.position;
   assign rsp_chan.key_out   = out_ff.key_out;
   assign rsp_chan.count     = out_ff.count;
   assign rsp_chan.first_key = out_ff.first_key;
   assign rsp_chan.last_key  = out_ff.last_key;

endmodule

// File: test/unique_key_array_set_core_test.sv
// self-checking testbench of the key set core with random traffic and capacity changes
module unique_key_array_set_core_test;
   import ukas_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [KEY_W-1:0] key;
      logic [IDX_W-1:0]        index;
   } set_req_type;

   logic clock;
   logic reset;

   ukas_req_if req_bus ();
   ukas_rsp_if rsp_bus ();
   ukas_csr_if csr_bus ();

   unique_key_array_set_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   set_req_type             pending_reqs[$];
   result_type              expected_results[$];
   logic signed [KEY_W-1:0] held_keys [DEPTH];
   int                      held_count;
   logic [CAP_W-1:0]        capacity_reg;
   logic signed [KEY_W-1:0] key_pool [20];
   int                      send_idle_pct;
   int                      recv_idle_pct;
   int                      fault_count;
   logic                    rsp_hold;
   event                    long_hold_go;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #(8 * 600000);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic result_type apply_set_request(set_req_type r);
      result_type res;
      int         hit;
      int         limit;
      res = '0;
      hit = -1;
      limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_keys[i] == r.key) hit = i;
      end
      case (r.op)
         OP_SEARCH: begin
            if (hit >= 0) res.position = hit[POS_W-1:0];
            else res.status = ST_NOTFOUND;
         end
         OP_INSERT: begin
            if (hit >= 0) begin
               res.status = ST_DUP;
               res.position = hit[POS_W-1:0];
            end else if (held_count >= limit) begin
               res.status = ST_FULL;
            end else begin
               res.position = held_count[POS_W-1:0];
               held_keys[held_count] = r.key;
               held_count++;
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               res.position = hit[POS_W-1:0];
               for (int i = hit; i < held_count - 1; i++) held_keys[i] = held_keys[i + 1];
               held_count--;
            end else begin
               res.status = ST_NOTFOUND;
            end
         end
         default: begin
            res.position = r.index;
            if (r.index < held_count) res.key_out = held_keys[r.index];
            else res.status = ST_RANGE;
         end
      endcase
      res.count = held_count[CNT_W-1:0];
      if (held_count > 0) begin
         res.first_key = held_keys[0];
         res.last_key = held_keys[held_count - 1];
      end
      return res;
   endfunction

   function automatic set_req_type random_request(bit growing);
      set_req_type r;
      int          pick;
      pick = $urandom_range(99);
      if (growing) begin
         r.op = (pick < 50) ? OP_INSERT : (pick < 65) ? OP_SEARCH :
                (pick < 80) ? OP_REMOVE : OP_READ;
      end else begin
         r.op = (pick < 20) ? OP_INSERT : (pick < 40) ? OP_SEARCH :
                (pick < 75) ? OP_REMOVE : OP_READ;
      end
      if ($urandom_range(99) < 80) r.key = key_pool[$urandom_range(19)];
      else r.key = $urandom;
      r.index = $urandom_range(15);
      return r;
   endfunction

   function automatic void push_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key,
                                        logic [IDX_W-1:0] index);
      set_req_type r;
      r.op = op;
      r.key = key;
      r.index = index;
      pending_reqs.push_back(r);
   endfunction

   task automatic wait_for_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      capacity_reg = value;
      csr_bus.valid <= 1'b0;
   endtask

   // request driver, predicts each word as it is accepted
   always @(posedge clock) begin
      set_req_type nxt;
      set_req_type cur;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            cur.op = req_bus.op;
            cur.key = req_bus.key;
            cur.index = req_bus.index;
            expected_results.push_back(apply_set_request(cur));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.op <= nxt.op;
               req_bus.key <= nxt.key;
               req_bus.index <= nxt.index;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result word: status %0d position %0d count %0d",
                           rsp_bus.status, rsp_bus.position, rsp_bus.count);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.position !== want.position ||
                   rsp_bus.key_out !== want.key_out || rsp_bus.count !== want.count ||
                   rsp_bus.first_key !== want.first_key ||
                   rsp_bus.last_key !== want.last_key) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"mismatch (expected/actual): status %0d/%0d position %0d/%0d ",
                               "key_out %0d/%0d count %0d/%0d first %0d/%0d last %0d/%0d"},
                              want.status, rsp_bus.status, want.position, rsp_bus.position,
                              want.key_out, rsp_bus.key_out, want.count, rsp_bus.count,
                              want.first_key, rsp_bus.first_key,
                              want.last_key, rsp_bus.last_key);
               end
            end
         end
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver stall so the core backs up into its input
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(long_hold_go);
         rsp_hold = 1'b1;
         repeat (80) @(negedge clock);
         rsp_hold = 1'b0;
      end
   end

   initial begin
      logic [CAP_W-1:0] phase_caps [8];
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_SEARCH;
      req_bus.key = '0;
      req_bus.index = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      held_count = 0;
      capacity_reg = CAP_RST;
      fault_count = 0;
      send_idle_pct = 26;
      recv_idle_pct = 60;
      phase_caps = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd1, 5'd16, 5'd5, 5'd31};
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < 20; i++) key_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      push_request(OP_SEARCH, 32'sd0, 4'd0);
      push_request(OP_REMOVE, 32'sd5, 4'd0);
      push_request(OP_READ, 32'sd0, 4'd0);
      push_request(OP_READ, 32'sd0, 4'd15);
      push_request(OP_INSERT, 32'sh8000_0000, 4'd0);
      push_request(OP_INSERT, 32'sh7fff_ffff, 4'd0);
      push_request(OP_INSERT, 32'sd0, 4'd0);
      push_request(OP_INSERT, -32'sd1, 4'd0);
      push_request(OP_INSERT, 32'sh7fff_ffff, 4'd0);
      push_request(OP_SEARCH, 32'sh7fff_ffff, 4'd0);
      push_request(OP_SEARCH, 32'sd12345, 4'd0);
      push_request(OP_READ, 32'sd0, 4'd0);
      push_request(OP_READ, 32'sd0, 4'd3);
      push_request(OP_READ, 32'sd0, 4'd4);
      push_request(OP_READ, 32'sd0, 4'd15);
      push_request(OP_REMOVE, 32'sh8000_0000, 4'd0);
      push_request(OP_REMOVE, -32'sd1, 4'd0);
      push_request(OP_REMOVE, 32'sd777, 4'd0);
      push_request(OP_SEARCH, 32'sd0, 4'd0);
      push_request(OP_READ, 32'sd0, 4'd1);
      wait_for_idle();

      for (int p = 0; p < 8; p++) begin
         send_idle_pct = (p < 3) ? 26 : (p < 6) ? 60 : 0;
         recv_idle_pct = (p < 3) ? 60 : (p < 6) ? 26 : 0;
         write_capacity(phase_caps[p]);
         @(negedge clock);
         for (int n = 0; n < 94; n++) begin
            if (p == 1 && n == 47) wait_for_idle();
            pending_reqs.push_back(random_request(((n / 30) % 2) == 0));
         end
         if (p == 0) -> long_hold_go;
         wait_for_idle();
      end

      repeat (40) @(negedge clock);
      if (fault_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
